@@ rtl/core/dttn_pkg.sv @@
// ----------------------------------------------------------------------------
// dttn_pkg
// Types, character codes and limits shared by the decimal text converter.
// ----------------------------------------------------------------------------
package dttn_pkg;

   localparam int FRAC_BITS_DEF  = 32;
   localparam int EXP_LIMIT_DEF  = 511;
   localparam int EXP_LIMIT_MAX  = 511;
   localparam int MANT_W         = 64;
   localparam int VALUE_W        = 64;
   // net decimal exponent: fraction shift plus signed exponent
   localparam int NET_W          = $clog2(EXP_LIMIT_MAX + 1) + 2;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_E_UP  = 8'h45;
   localparam logic [7:0] CH_E_LO  = 8'h65;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_INT,
      PH_FRAC,
      PH_ESIGN,
      PH_EDIG,
      PH_TRAIL
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_ROUND,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_q31_32;
      logic                      parse_error;
   } rsp_payload_type;

   typedef struct packed {
      logic                    parse_error;
      logic                    negative;
      logic [MANT_W-1:0]       mantissa;
      logic signed [NET_W-1:0] net_exp;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/dttn_front.sv @@
// ----------------------------------------------------------------------------
// dttn_front
// Character parser: accumulates mantissa, fraction shift and exponent, and
// hands one job per text to the queue on the last character.
// ----------------------------------------------------------------------------
module dttn_front
   import dttn_pkg::*;
#(
   parameter int EXPONENT_LIMIT = EXP_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_payload_type  req_payload,
   output logic             req_stall,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   localparam int EXP_W = $clog2(EXPONENT_LIMIT + 1);
   localparam int FS_W  = EXP_W + 1;
   localparam int EV_W  = EXP_W + 4;
   localparam logic signed [FS_W-1:0] FS_MAX = FS_W'(EXPONENT_LIMIT);
   localparam logic signed [FS_W-1:0] FS_MIN = -FS_MAX;
   localparam logic signed [FS_W-1:0] FS_ONE = FS_W'(1);
   localparam logic [EV_W-1:0]        EV_LIM = EV_W'(EXPONENT_LIMIT);

   phase_type               phase_ff, phase_in, f_phase;
   logic                    neg_ff, neg_in, f_neg;
   logic [MANT_W-1:0]       mant_ff, mant_in, f_mant;
   logic                    dseen_ff, dseen_in, f_dseen;
   logic signed [FS_W-1:0]  fs_ff, fs_in, f_fs;
   logic [EXP_W-1:0]        exp_ff, exp_in, f_exp;
   logic                    eneg_ff, eneg_in, f_eneg;
   logic                    err_ff, err_in, f_err;
   logic                    pt_ff, pt_in, f_pt;

   logic [7:0]              c;
   logic                    is_dig, is_sp, is_plus, is_minus, is_pt, is_e;
   logic [3:0]              d;
   logic [MANT_W+3:0]       prod;
   logic                    fits;
   logic [EV_W-1:0]         ev;
   logic [EXP_W-1:0]        exp_sat;
   logic                    take_int, take_frac, take_exp;
   logic                    accept;
   logic signed [NET_W-1:0] fs_ext, e_ext;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   assign c        = req_payload.char_code;
   assign is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_sp    = (c == CH_SPACE);
   assign is_plus  = (c == CH_PLUS);
   assign is_minus = (c == CH_MINUS);
   assign is_pt    = (c == CH_POINT);
   assign is_e     = (c == CH_E_UP) || (c == CH_E_LO);
   assign d        = is_dig ? c[3:0] : 4'd0;

   assign prod    = {4'd0, mant_ff} * (MANT_W+4)'(10) + (MANT_W+4)'(d);
   assign fits    = (prod[MANT_W+3:MANT_W] == 4'd0);
   assign ev      = EV_W'(exp_ff) * EV_W'(10) + EV_W'(d);
   assign exp_sat = (ev > EV_LIM) ? EXP_W'(EXPONENT_LIMIT) : ev[EXP_W-1:0];

   always_comb begin
      f_phase   = phase_ff;
      f_neg     = neg_ff;
      f_mant    = mant_ff;
      f_dseen   = dseen_ff;
      f_fs      = fs_ff;
      f_exp     = exp_ff;
      f_eneg    = eneg_ff;
      f_err     = err_ff;
      f_pt      = pt_ff;
      take_int  = 1'b0;
      take_frac = 1'b0;
      take_exp  = 1'b0;
      if (!err_ff) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_sp) begin
                  f_phase = PH_LEAD;
               end else if (is_plus) begin
                  f_phase = PH_INT;
               end else if (is_minus) begin
                  f_neg   = 1'b1;
                  f_phase = PH_INT;
               end else if (is_dig) begin
                  take_int = 1'b1;
                  f_phase  = PH_INT;
               end else if (is_pt) begin
                  f_pt    = 1'b1;
                  f_phase = PH_FRAC;
               end else if (is_e) begin
                  f_phase = PH_ESIGN;
               end else begin
                  f_err = 1'b1;
               end
            end
            PH_INT: begin
               if (is_dig) begin
                  take_int = 1'b1;
               end else if (is_pt) begin
                  f_pt    = 1'b1;
                  f_phase = PH_FRAC;
               end else if (is_e) begin
                  f_phase = PH_ESIGN;
               end else if (is_sp) begin
                  f_phase = PH_TRAIL;
               end else begin
                  f_err = 1'b1;
               end
            end
            PH_FRAC: begin
               if (is_dig) begin
                  take_frac = 1'b1;
               end else if (is_e) begin
                  f_phase = PH_ESIGN;
               end else if (is_sp) begin
                  f_phase = PH_TRAIL;
               end else begin
                  f_err = 1'b1;
               end
            end
            PH_ESIGN: begin
               if (is_plus) begin
                  f_phase = PH_EDIG;
               end else if (is_minus) begin
                  f_eneg  = 1'b1;
                  f_phase = PH_EDIG;
               end else if (is_dig) begin
                  take_exp = 1'b1;
                  f_phase  = PH_EDIG;
               end else if (is_sp) begin
                  f_phase = PH_TRAIL;
               end else begin
                  f_err = 1'b1;
               end
            end
            PH_EDIG: begin
               if (is_dig) begin
                  take_exp = 1'b1;
               end else if (is_sp) begin
                  f_phase = PH_TRAIL;
               end else begin
                  f_err = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (!is_sp) begin
                  f_err = 1'b1;
               end
            end
            default: begin
               f_err = 1'b1;
            end
         endcase
      end
      // dropped integer digits raise the decimal shift
      if (take_int || take_frac) begin
         f_dseen = 1'b1;
         if (fits) begin
            f_mant = prod[MANT_W-1:0];
            if (take_frac && (fs_ff > FS_MIN)) begin
               f_fs = fs_ff - FS_ONE;
            end
         end else if (take_int && (fs_ff < FS_MAX)) begin
            f_fs = fs_ff + FS_ONE;
         end
      end
      if (take_exp) begin
         f_exp = exp_sat;
      end
   end

   assign fs_ext = {{(NET_W-FS_W){f_fs[FS_W-1]}}, f_fs};
   assign e_ext  = {{(NET_W-EXP_W){1'b0}}, f_exp};

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mant_in  = mant_ff;
      dseen_in = dseen_ff;
      fs_in    = fs_ff;
      exp_in   = exp_ff;
      eneg_in  = eneg_ff;
      err_in   = err_ff;
      pt_in    = pt_ff;
      push     = 1'b0;
      push_job.parse_error = f_err || (!f_dseen && !f_pt);
      push_job.negative    = f_neg;
      push_job.mantissa    = f_mant;
      push_job.net_exp     = f_eneg ? (fs_ext - e_ext) : (fs_ext + e_ext);
      if (accept) begin
         if (req_payload.last_char) begin
            push     = 1'b1;
            phase_in = PH_LEAD;
            neg_in   = 1'b0;
            mant_in  = '0;
            dseen_in = 1'b0;
            fs_in    = '0;
            exp_in   = '0;
            eneg_in  = 1'b0;
            err_in   = 1'b0;
            pt_in    = 1'b0;
         end else begin
            phase_in = f_phase;
            neg_in   = f_neg;
            mant_in  = f_mant;
            dseen_in = f_dseen;
            fs_in    = f_fs;
            exp_in   = f_exp;
            eneg_in  = f_eneg;
            err_in   = f_err;
            pt_in    = f_pt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         neg_ff   <= 1'b0;
         mant_ff  <= '0;
         dseen_ff <= 1'b0;
         fs_ff    <= '0;
         exp_ff   <= '0;
         eneg_ff  <= 1'b0;
         err_ff   <= 1'b0;
         pt_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mant_ff  <= mant_in;
         dseen_ff <= dseen_in;
         fs_ff    <= fs_in;
         exp_ff   <= exp_in;
         eneg_ff  <= eneg_in;
         err_ff   <= err_in;
         pt_ff    <= pt_in;
      end
   end

endmodule

@@ rtl/core/dttn_queue.sv @@
// ----------------------------------------------------------------------------
// dttn_queue
// Short first-word-fall-through queue of parsed jobs between the parser and
// the scaler.
// ----------------------------------------------------------------------------
module dttn_queue
   import dttn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          pop_job,
   output queue_status_type q_status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/dttn_back.sv @@
// ----------------------------------------------------------------------------
// dttn_back
// Scaler: multiplies by ten per cycle for a positive net exponent, or
// divides a wide value by ten a byte per cycle and rounds for a negative
// one, then saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module dttn_back
   import dttn_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          pop_job,
   output logic             pop,
   output logic             rsp_valid,
   output rsp_payload_type  rsp_payload,
   input  logic             rsp_stall
);

   localparam int VW     = ((MANT_W + FRAC_BITS + 1 + 7) / 8) * 8;
   localparam int NCH    = VW / 8;
   localparam int IDX_W  = $clog2(NCH);
   localparam int CNT_W  = NET_W - 1;
   localparam logic [MANT_W-1:0]  LIM_X     = MANT_W'(1) << (63 - FRAC_BITS);
   localparam logic [VALUE_W-1:0] MOST_NEG  = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] MOST_POS  = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [27:0]        RECIP_TEN = 28'd52429;

   back_state_type        state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic                  perr_ff, perr_in;
   logic [MANT_W-1:0]     x_ff, x_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VW-1:0]         v_ff, v_in;
   logic [3:0]            rem_ff, rem_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic                  over_ff, over_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic signed [NET_W-1:0] net_mag;
   logic [MANT_W-1:0]     x10;
   logic [11:0]           cur;
   logic [27:0]           qprod;
   logic [7:0]            q;
   logic [11:0]           r;
   logic [VW:0]           rsum;
   logic [VW-1:0]         half;
   rsp_payload_type       result;
   logic                  out_free;

   assign net_mag = pop_job.net_exp[NET_W-1] ? -pop_job.net_exp : pop_job.net_exp;
   assign x10     = x_ff * MANT_W'(10);
   assign cur     = {rem_ff, v_ff[VW-1 -: 8]};
   assign qprod   = 28'(cur) * RECIP_TEN;
   assign q       = qprod[26:19];
   assign r       = cur - 12'(q) * 12'd10;
   assign rsum    = {1'b0, v_ff} + (VW+1)'(1);
   assign half    = rsum[VW:1];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      result.parse_error = perr_ff;
      if (perr_ff) begin
         result.value_q31_32 = '0;
      end else if (neg_ff) begin
         result.value_q31_32 = (over_ff || (mag_ff > MOST_NEG)) ? MOST_NEG : (~mag_ff + 1'b1);
      end else begin
         result.value_q31_32 = (over_ff || mag_ff[VALUE_W-1]) ? MOST_POS : mag_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      neg_in         = neg_ff;
      perr_in        = perr_ff;
      x_in           = x_ff;
      cnt_in         = cnt_ff;
      v_in           = v_ff;
      rem_in         = rem_ff;
      idx_in         = idx_ff;
      mag_in         = mag_ff;
      over_in        = over_ff;
      pop            = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               neg_in  = pop_job.negative;
               perr_in = pop_job.parse_error;
               over_in = 1'b0;
               mag_in  = '0;
               x_in    = pop_job.mantissa;
               v_in    = VW'(pop_job.mantissa) << (FRAC_BITS + 1);
               cnt_in  = net_mag[CNT_W-1:0];
               idx_in  = '0;
               rem_in  = '0;
               if (pop_job.parse_error || (pop_job.mantissa == '0)) begin
                  state_in = BK_FINISH;
               end else if (!pop_job.net_exp[NET_W-1]) begin
                  if (pop_job.mantissa > LIM_X) begin
                     over_in  = 1'b1;
                     state_in = BK_FINISH;
                  end else begin
                     state_in = BK_MUL;
                  end
               end else begin
                  state_in = BK_DIV;
               end
            end
         end
         BK_MUL: begin
            if (cnt_ff == '0) begin
               mag_in   = x_ff << FRAC_BITS;
               state_in = BK_FINISH;
            end else if (x10 > LIM_X) begin
               over_in  = 1'b1;
               state_in = BK_FINISH;
            end else begin
               x_in   = x10;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         BK_DIV: begin
            if ((idx_ff == '0) && ((cnt_ff == '0) || (v_ff == '0))) begin
               state_in = BK_ROUND;
            end else begin
               v_in = {v_ff[VW-9:0], q};
               if (idx_ff == IDX_W'(NCH - 1)) begin
                  idx_in = '0;
                  rem_in = '0;
                  cnt_in = cnt_ff - CNT_W'(1);
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
                  rem_in = r[3:0];
               end
            end
         end
         BK_ROUND: begin
            over_in  = |half[VW-1:VALUE_W];
            mag_in   = half[VALUE_W-1:0];
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = result;
               state_in       = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff         <= neg_in;
      perr_ff        <= perr_in;
      x_ff           <= x_in;
      cnt_ff         <= cnt_in;
      v_ff           <= v_in;
      rem_ff         <= rem_in;
      idx_ff         <= idx_in;
      mag_ff         <= mag_in;
      over_ff        <= over_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/core/decimal_text_to_number.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_number
// Streams decimal number text in, one character per transfer, and returns
// one signed fixed-point value with an error flag per text.
//
//   channel  dir  handshake           payload
//   req_     in   req_valid/stall     char_code, last_char
//   rsp_     out  rsp_valid/stall     value_q31_32, parse_error
//
// Characters are taken one per cycle; stall rises only while the job queue
// is full. Scaling multiplies by ten once per unit of a positive net exponent
// or, for negative exponents, divides by ten a byte at a time (NCH bytes, 13
// for 32 fraction bits) until the exponent is used up or the value reaches
// zero; the scaler finishes one text before it takes the next from the queue.
// Synchronous reset clears the parser, queue and scaler; output stall holds the result register.
// ----------------------------------------------------------------------------
module decimal_text_to_number
   import dttn_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int EXPONENT_LIMIT = EXP_LIMIT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   queue_status_type q_status;
   logic             push, pop;
   job_type          push_job, pop_job;

   dttn_front #(
      .EXPONENT_LIMIT(EXPONENT_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .push_job   (push_job)
   );

   dttn_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .pop_job (pop_job),
      .q_status(q_status)
   );

   dttn_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_job    (pop_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall  (rsp_stall)
   );

endmodule

@@ rtl/core/dttn_checker.sv @@
// ----------------------------------------------------------------------------
// dttn_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module dttn_checker
   import dttn_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.parse_error |-> rsp_payload.value_q31_32 == '0)
      else $error("error result with non-zero value");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind decimal_text_to_number dttn_checker u_dttn_checker (.*);

@@ dv/dttn_checker_pkg.sv @@
// ----------------------------------------------------------------------------
// dttn_checker_pkg
// Scoreboard for the decimal text converter: follows the parse of every
// accepted character, computes the expected value and error flag of each
// text and compares them with the results leaving the block.
// ----------------------------------------------------------------------------
package dttn_checker_pkg;
   import dttn_pkg::*;

   class conversion_checker;
      phase_type       text_phase;
      logic            negative;
      logic [63:0]     mantissa;
      int              digits;
      int              dec_shift;
      int              exponent;
      logic            exp_negative;
      logic            malformed;
      logic            point_seen;
      rsp_payload_type expected_values[$];
      int              mismatches;

      function new();
         mismatches = 0;
         clear_text();
      endfunction

      function void clear_text();
         text_phase   = PH_LEAD;
         negative     = 1'b0;
         mantissa     = 64'd0;
         digits       = 0;
         dec_shift    = 0;
         exponent     = 0;
         exp_negative = 1'b0;
         malformed    = 1'b0;
         point_seen   = 1'b0;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("mismatch: %s", msg);
      endtask

      // digits that no longer fit are dropped; integer ones move the point
      function void add_digit(logic [63:0] d, logic in_fraction);
         if (digits < 255) begin
            digits++;
         end
         if (mantissa <= (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
            mantissa = mantissa * 64'd10 + d;
            if (in_fraction && dec_shift > -EXP_LIMIT_DEF) begin
               dec_shift--;
            end
         end else if (!in_fraction && dec_shift < EXP_LIMIT_DEF) begin
            dec_shift++;
         end
      endfunction

      function void add_exp_digit(int d);
         int v;
         v = exponent * 10 + d;
         exponent = (v > EXP_LIMIT_DEF) ? EXP_LIMIT_DEF : v;
      endfunction

      function void take_char(logic [7:0] c);
         logic        is_digit;
         logic        is_e;
         logic [63:0] d;
         is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
         is_e     = (c == CH_E_UP) || (c == CH_E_LO);
         d        = is_digit ? 64'(c - CH_ZERO) : 64'd0;
         case (text_phase)
            PH_LEAD: begin
               if (c == CH_SPACE) begin
               end else if (c == CH_PLUS) begin
                  text_phase = PH_INT;
               end else if (c == CH_MINUS) begin
                  negative   = 1'b1;
                  text_phase = PH_INT;
               end else if (is_digit) begin
                  add_digit(d, 1'b0);
                  text_phase = PH_INT;
               end else if (c == CH_POINT) begin
                  point_seen = 1'b1;
                  text_phase = PH_FRAC;
               end else if (is_e) begin
                  text_phase = PH_ESIGN;
               end else begin
                  malformed = 1'b1;
               end
            end
            PH_INT: begin
               if (is_digit) begin
                  add_digit(d, 1'b0);
               end else if (c == CH_POINT) begin
                  point_seen = 1'b1;
                  text_phase = PH_FRAC;
               end else if (is_e) begin
                  text_phase = PH_ESIGN;
               end else if (c == CH_SPACE) begin
                  text_phase = PH_TRAIL;
               end else begin
                  malformed = 1'b1;
               end
            end
            PH_FRAC: begin
               if (is_digit) begin
                  add_digit(d, 1'b1);
               end else if (is_e) begin
                  text_phase = PH_ESIGN;
               end else if (c == CH_SPACE) begin
                  text_phase = PH_TRAIL;
               end else begin
                  malformed = 1'b1;
               end
            end
            PH_ESIGN: begin
               if (c == CH_PLUS) begin
                  text_phase = PH_EDIG;
               end else if (c == CH_MINUS) begin
                  exp_negative = 1'b1;
                  text_phase   = PH_EDIG;
               end else if (is_digit) begin
                  add_exp_digit(int'(d));
                  text_phase = PH_EDIG;
               end else if (c == CH_SPACE) begin
                  text_phase = PH_TRAIL;
               end else begin
                  malformed = 1'b1;
               end
            end
            PH_EDIG: begin
               if (is_digit) begin
                  add_exp_digit(int'(d));
               end else if (c == CH_SPACE) begin
                  text_phase = PH_TRAIL;
               end else begin
                  malformed = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (c != CH_SPACE) begin
                  malformed = 1'b1;
               end
            end
            default: malformed = 1'b1;
         endcase
      endfunction

      // |mantissa * 10^net| in fixed point, rounded half away from zero
      function logic [63:0] scaled_magnitude(int net, output logic over);
         logic [63:0]  x;
         logic [63:0]  mul_limit;
         logic [127:0] wide;
         int           i;
         over      = 1'b0;
         mul_limit = 64'd1 << (63 - FRAC_BITS_DEF);
         if (mantissa == 64'd0) begin
            return 64'd0;
         end
         if (net >= 0) begin
            x = mantissa;
            if (x > mul_limit) begin
               over = 1'b1;
               return 64'd0;
            end
            for (i = 0; i < net; i++) begin
               x = x * 64'd10;
               if (x > mul_limit) begin
                  over = 1'b1;
                  return 64'd0;
               end
            end
            return x << FRAC_BITS_DEF;
         end
         wide = {64'd0, mantissa} << (FRAC_BITS_DEF + 1);
         for (i = 0; i < -net && wide != 128'd0; i++) begin
            wide = wide / 128'd10;
         end
         wide = (wide + 128'd1) >> 1;
         if (wide[127:64] != 64'd0) begin
            over = 1'b1;
            return 64'd0;
         end
         return wide[63:0];
      endfunction

      function void note_char(req_payload_type item);
         rsp_payload_type want;
         int              net;
         logic            over;
         logic [63:0]     mag;
         if (!malformed) begin
            take_char(item.char_code);
         end
         if (!item.last_char) begin
            return;
         end
         want = '0;
         want.parse_error = malformed || (digits == 0 && !point_seen);
         if (!want.parse_error) begin
            net = dec_shift + (exp_negative ? -exponent : exponent);
            mag = scaled_magnitude(net, over);
            if (negative) begin
               if (over || mag > 64'h8000_0000_0000_0000) begin
                  want.value_q31_32 = 64'h8000_0000_0000_0000;
               end else begin
                  want.value_q31_32 = ~mag + 64'd1;
               end
            end else begin
               if (over || mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
                  want.value_q31_32 = 64'h7FFF_FFFF_FFFF_FFFF;
               end else begin
                  want.value_q31_32 = mag;
               end
            end
         end
         expected_values.push_back(want);
         clear_text();
      endfunction

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %h error %b",
                                      got.value_q31_32, got.parse_error));
            return;
         end
         want = expected_values.pop_front();
         if (got.value_q31_32 !== want.value_q31_32) begin
            report_mismatch($sformatf("value %h, want %h",
                                      got.value_q31_32, want.value_q31_32));
         end
         if (got.parse_error !== want.parse_error) begin
            report_mismatch($sformatf("error flag %b, want %b",
                                      got.parse_error, want.parse_error));
         end
      endtask
   endclass

endpackage

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives number texts into the decimal text converter one character per
// transfer: a few hand-picked texts, then random well-formed, corrupted and
// noise texts under changing sender gaps and receiver stalls, including one
// long receiver hold-off that backs the block up. Every result is checked.
// ----------------------------------------------------------------------------
module tb_top;
   import dttn_pkg::*;
   import dttn_checker_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      MODE_FREE,
      MODE_SEND_IDLE,
      MODE_RECV_STALL,
      MODE_BOTH,
      MODE_PRESSURE
   } traffic_type;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PHASE_CHARS   = 140;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 500;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   conversion_checker sb = new();
   traffic_type       mode = MODE_FREE;
   logic [7:0]        text_buf[$];
   int                chars_sent = 0;
   int                hold_left = HOLD_CYCLES;
   int                cycle_count = 0;

   decimal_text_to_number uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_payload);
      end
   end

   // receiver side; the pressure phase starts with one long hold-off
   always @(negedge clock) begin
      if (mode == MODE_PRESSURE && hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (mode == MODE_RECV_STALL) begin
         rsp_stall <= ($urandom_range(99) < 61);
      end else if (mode == MODE_BOTH) begin
         rsp_stall <= ($urandom_range(99) < 23);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int send_gap_percent();
      if (mode == MODE_SEND_IDLE) begin
         return 61;
      end
      if (mode == MODE_BOTH) begin
         return 23;
      end
      return 0;
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'(CH_ZERO + $urandom_range(9));
   endfunction

   function automatic int digit_run();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return $urandom_range(0, 4);
      end
      if (pick < 92) begin
         return $urandom_range(5, 12);
      end
      return $urandom_range(18, 26);
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_char(logic [7:0] ch, logic last);
      int gap;
      gap = send_gap_percent();
      if (gap != 0 && $urandom_range(99) < gap) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < gap);
      end
      req_valid             <= 1'b1;
      req_payload.char_code <= ch;
      req_payload.last_char <= last;
      do @(posedge clock); while (req_stall);
      sb.note_char(req_payload);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_buf.size(); i++) begin
         send_char(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   task automatic send_string(string s);
      int i;
      text_buf.delete();
      for (i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
      send_text();
   endtask

   task automatic make_number_text();
      int style;
      int n;
      style = $urandom_range(99);
      text_buf.delete();
      if (style < 8) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) text_buf.push_back(CH_SPACE);
      end
      case ($urandom_range(2))
         0: text_buf.push_back(CH_PLUS);
         1: text_buf.push_back(CH_MINUS);
         default: ;
      endcase
      repeat (digit_run()) text_buf.push_back(random_digit());
      if ($urandom_range(2) != 0) begin
         text_buf.push_back(CH_POINT);
         repeat (digit_run()) text_buf.push_back(random_digit());
      end
      if ($urandom_range(2) == 0) begin
         text_buf.push_back($urandom_range(1) ? CH_E_UP : CH_E_LO);
         case ($urandom_range(2))
            0: text_buf.push_back(CH_PLUS);
            1: text_buf.push_back(CH_MINUS);
            default: ;
         endcase
         n = $urandom_range(99);
         n = (n < 60) ? 1 : (n < 85) ? 2 : (n < 93) ? 0 : $urandom_range(3, 4);
         repeat (n) text_buf.push_back(random_digit());
      end
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 2)) text_buf.push_back(CH_SPACE);
      end
      if (text_buf.size() == 0) begin
         text_buf.push_back(random_digit());
      end
      if (style < 20) begin
         text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
      end
   endtask

   task automatic run_phase(traffic_type m);
      int start;
      mode  = m;
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) begin
         make_number_text();
         send_text();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_string(".");
      send_string("-");
      send_string(" ");
      send_string("1e");
      send_string("e5");
      send_string("9e9");
      send_string("-9e9");
      send_string("1e-11");
      send_string("+1 ");
      send_string("7x");
      text_buf = {8'h00};
      send_text();
      text_buf = {8'hFF};
      send_text();

      run_phase(MODE_FREE);
      run_phase(MODE_SEND_IDLE);
      run_phase(MODE_RECV_STALL);
      run_phase(MODE_BOTH);
      run_phase(MODE_PRESSURE);
      run_phase(MODE_FREE);
      req_valid <= 1'b0;

      while (sb.expected_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/dttn_pkg.sv
rtl/core/dttn_front.sv
rtl/core/dttn_queue.sv
rtl/core/dttn_back.sv
rtl/core/decimal_text_to_number.sv
rtl/core/dttn_checker.sv
dv/dttn_checker_pkg.sv
dv/tb_top.sv
